// ----- hw/rtl/adl_pkg.sv -----
// shared types and constants for the audio decimator with loudness
// no dependencies
`default_nettype none
package adl_pkg;
    localparam int TAPS = 16;
    localparam int PTR_W = $clog2(TAPS);
    localparam int FRAME_WIDE = 80;
    localparam int FRAME_NARROW = 160;
    localparam logic [1:0] REG_CAPTURE = 2'd0;
    localparam logic [1:0] REG_RATE = 2'd1;
    localparam logic [1:0] REG_WIDE = 2'd2;
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ = 1'b1;
    localparam logic KIND_AUDIO = 1'b0;
    localparam logic KIND_REPORT = 1'b1;
    localparam logic [7:0] RATE_FULL = 8'd8;
    localparam logic [7:0] RATE_HALF = 8'd4;
    localparam logic [7:0] RATE_QUARTER = 8'd2;
    localparam logic [7:0] RATE_EIGHTH = 8'd1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PUSH, ST_MAC, ST_MAC_LAST, ST_DIV, ST_OUT
    } state_t;

    function automatic logic signed [15:0] coeff(input logic [PTR_W-1:0] i);
        logic signed [15:0] c;
        c = 16'sd0;
        case (i)
            4'd0, 4'd15: c = -16'sd86;
            4'd1, 4'd14: c = 16'sd91;
            4'd2, 4'd13: c = 16'sd422;
            4'd3, 4'd12: c = -16'sd91;
            4'd4, 4'd11: c = -16'sd1747;
            4'd5, 4'd10: c = -16'sd934;
            4'd6, 4'd9: c = 16'sd5604;
            4'd7, 4'd8: c = 16'sd13125;
            default: c = 16'sd0;
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/audio_decimator_with_loudness_core.sv -----
// top level: three-stage decimating fir with delay lines in one memory,
// frame marking and loudness tracking; depends on adl_pkg
// one item at a time, set by the shared mac loop over the tap memory;
// a read runs a serial 41/16 divide for the mean square. async active-low
// reset clears control and loudness state; a valid bit per tap makes
// unwritten taps read as zero
`default_nettype none
module audio_decimator_with_loudness_core
    import adl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               opcode,
    input  wire logic [11:0]        sample_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    kind,
    output logic signed [14:0]      audio_value,
    output logic                    frame_last,
    output logic [11:0]             peak_level,
    output logic [23:0]             mean_square,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [7:0]         cfg_data
);
    // tap memory: 3 lines of TAPS entries, address = {line, ptr}
    logic signed [15:0] mem [3*TAPS];
    logic signed [15:0] rd_reg;
    logic               mem_we;
    logic [PTR_W+1:0]   wr_addr, rd_addr;
    logic signed [15:0] wr_data;

    // taps reset to zero: valid bit per entry
    logic [3*TAPS-1:0] tv_reg;

    state_t state_reg, state_next;
    logic        cap_reg, wide_reg;
    logic [7:0]  rate_reg;
    logic [PTR_W-1:0] wp_reg [3];
    logic [2:0]  phase_reg;
    logic [7:0]  fpos_reg;
    logic [11:0] peak_reg;
    logic [40:0] ssum_reg;
    logic [15:0] scnt_reg;
    logic [1:0]  stg_reg;            // line being pushed/filtered
    logic signed [15:0] push_reg;    // value entering line stg_reg
    logic [PTR_W:0] ti_reg;          // mac tap counter
    logic [PTR_W-1:0] ridx_reg;
    logic signed [36:0] acc_reg;
    logic        rvalid_reg;         // read data valid-tap flag
    logic [PTR_W-1:0] rtap_reg;
    logic [40:0] rem_reg;            // divide: dividend/quotient shift
    logic [16:0] dr_reg;
    logic [5:0]  dcnt_reg;
    logic        okind_reg, olast_reg;
    logic signed [14:0] oval_reg;
    logic [11:0] opeak_reg;
    logic [23:0] oms_reg;
    logic        ovalid_reg;
    logic [11:0] sq_a;
    logic [23:0] sq_prod;
    logic        opcode_rd_q;

    assign in_stall = (state_reg != ST_IDLE) || ovalid_reg;
    assign out_valid = ovalid_reg;
    assign kind = okind_reg;
    assign audio_value = oval_reg;
    assign frame_last = olast_reg;
    assign peak_level = opeak_reg;
    assign mean_square = oms_reg;

    logic in_xfer;
    assign in_xfer = in_valid && !in_stall;

    // emission select per stage output
    function automatic logic want(input logic [7:0] r, input logic [1:0] lvl);
        logic w;
        case (lvl)
            2'd0: w = (r == RATE_HALF);
            2'd1: w = (r == RATE_QUARTER);
            2'd2: w = (r == RATE_EIGHTH);
            default: w = 1'b0;
        endcase
        return w;
    endfunction

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_xfer)
                    state_next = (opcode == OP_READ) ? ST_DIV : ST_PUSH;
            ST_PUSH:
                // after push, filter line stg when phase reaches that level
                if ((stg_reg == 2'd0 && !phase_reg[0]) ||
                    (stg_reg == 2'd1 && phase_reg[1:0] == 2'd0) ||
                    (stg_reg == 2'd2 && phase_reg == 3'd0))
                    state_next = ST_MAC;
                else
                    state_next = ST_OUT;
            ST_MAC:
                if (ti_reg == (PTR_W+1)'(TAPS))
                    state_next = ST_MAC_LAST;
            ST_MAC_LAST:
                state_next = (stg_reg == 2'd2) ? ST_OUT : ST_PUSH;
            ST_DIV:
                if (dcnt_reg == 6'd0)
                    state_next = ST_OUT;
            ST_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // memory port control
    always_comb
    begin
        mem_we = (state_reg == ST_PUSH);
        wr_addr = {stg_reg, wp_reg[stg_reg]};
        wr_data = push_reg;
        rd_addr = {stg_reg, ridx_reg};
    end

    logic signed [36:0] filt_acc;
    logic signed [21:0] filt_q;
    logic signed [15:0] tapv;
    logic signed [31:0] mac_prod;
    assign tapv = rvalid_reg ? rd_reg : 16'sd0;
    assign mac_prod = coeff(rtap_reg) * tapv;
    assign filt_acc = acc_reg + 37'(mac_prod);
    // acc_reg holds all taps once the mac loop is done
    assign filt_q = 22'(acc_reg >>> 15);
    assign sq_a = sample_value;
    assign sq_prod = sq_a * sq_a;

    logic [7:0] flen;
    assign flen = wide_reg ? 8'(FRAME_WIDE) : 8'(FRAME_NARROW);

    logic [17:0] dtrial;
    logic [16:0] dr_shift;
    assign dr_shift = {dr_reg[15:0], rem_reg[40]};
    assign dtrial = {1'b0, dr_shift} - {2'b0, scnt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg <= 1'b0;
            rate_reg <= RATE_HALF;
            wide_reg <= 1'b1;
            for (int k = 0; k < 3; k++) wp_reg[k] <= '0;
            phase_reg <= '0;
            fpos_reg <= '0;
            peak_reg <= '0;
            ssum_reg <= '0;
            scnt_reg <= '0;
            tv_reg <= '0;
            ovalid_reg <= 1'b0;
            okind_reg <= KIND_AUDIO;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CAPTURE: cap_reg <= cfg_data[0];
                    REG_RATE: rate_reg <= cfg_data;
                    REG_WIDE: wide_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (in_xfer)
                    begin
                        if (opcode == OP_READ)
                        begin
                            okind_reg <= KIND_REPORT;
                            olast_reg <= 1'b0;
                            oval_reg <= '0;
                            opeak_reg <= peak_reg;
                            oms_reg <= '0;
                            rem_reg <= ssum_reg;
                            dr_reg <= '0;
                            dcnt_reg <= 6'd41;
                        end
                        else
                        begin
                            opeak_reg <= '0;
                            oms_reg <= '0;
                            if (sample_value > peak_reg)
                                peak_reg <= sample_value;
                            if (scnt_reg != 16'hFFFF)
                            begin
                                ssum_reg <= ssum_reg + 41'(sq_prod);
                                scnt_reg <= scnt_reg + 16'd1;
                            end
                            phase_reg <= phase_reg + 3'd1;
                            stg_reg <= 2'd0;
                            push_reg <= 16'(sample_value);
                            if (rate_reg == RATE_FULL && cap_reg)
                            begin
                                okind_reg <= KIND_AUDIO;
                                oval_reg <= wide_reg ? 15'(sample_value)
                                                     : 15'(sample_value >> 4);
                                olast_reg <= (9'(fpos_reg) + 9'd1 >= 9'(flen));
                                fpos_reg <= (9'(fpos_reg) + 9'd1 >= 9'(flen))
                                            ? 8'd0 : fpos_reg + 8'd1;
                            end
                            else
                            begin
                                okind_reg <= KIND_REPORT; // marks no result yet
                                oval_reg <= '0;
                                olast_reg <= 1'b0;
                            end
                        end
                    end
                ST_PUSH:
                begin
                    tv_reg[{stg_reg, wp_reg[stg_reg]}] <= 1'b1;
                    wp_reg[stg_reg] <= wp_reg[stg_reg] + 1'b1;
                    ridx_reg <= wp_reg[stg_reg];
                    ti_reg <= '0;
                    acc_reg <= '0;
                end
                ST_MAC:
                begin
                    // issue read of tap ti (newest first), accumulate previous
                    if (ti_reg != '0)
                        acc_reg <= filt_acc;
                    rtap_reg <= ti_reg[PTR_W-1:0];
                    rvalid_reg <= tv_reg[{stg_reg, ridx_reg}];
                    ridx_reg <= ridx_reg - 1'b1;
                    ti_reg <= ti_reg + 1'b1;
                end
                ST_MAC_LAST:
                begin
                    push_reg <= filt_q[15:0];
                    stg_reg <= stg_reg + 2'd1;
                    if (want(rate_reg, stg_reg) && cap_reg)
                    begin
                        okind_reg <= KIND_AUDIO;
                        oval_reg <= wide_reg ? 15'(filt_q[15:0])
                                             : 15'($signed(filt_q[15:4]));
                        olast_reg <= (9'(fpos_reg) + 9'd1 >= 9'(flen));
                        fpos_reg <= (9'(fpos_reg) + 9'd1 >= 9'(flen))
                                    ? 8'd0 : fpos_reg + 8'd1;
                    end
                end
                ST_DIV:
                    if (dcnt_reg != 6'd0)
                    begin
                        dcnt_reg <= dcnt_reg - 6'd1;
                        if (!dtrial[17])
                        begin
                            dr_reg <= dtrial[16:0];
                            rem_reg <= {rem_reg[39:0], 1'b1};
                        end
                        else
                        begin
                            dr_reg <= dr_shift;
                            rem_reg <= {rem_reg[39:0], 1'b0};
                        end
                    end
                    else
                    begin
                        oms_reg <= (scnt_reg == '0) ? 24'd0 : rem_reg[23:0];
                        peak_reg <= '0;
                        ssum_reg <= '0;
                        scnt_reg <= '0;
                    end
                ST_OUT:
                    if (okind_reg == KIND_AUDIO || opcode_rd_q)
                        ovalid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // remember whether the item in flight is a read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            opcode_rd_q <= 1'b0;
        else if (in_xfer)
            opcode_rd_q <= (opcode == OP_READ);
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_report_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_REPORT) |-> opcode_rd_q)
        else $error("report without read");
    a_audio_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_AUDIO) |-> (peak_level == '0 && mean_square == '0))
        else $error("audio result carries loudness");
`endif
endmodule
`default_nettype wire

// ----- tb/tb_audio_decimator_with_loudness_core.sv -----
// testbench for audio_decimator_with_loudness_core: directed table, then random phases
// checked against an in-bench model of the fir cascade, framing and loudness; needs adl_pkg
`timescale 1ns / 1ps
module tb_audio_decimator_with_loudness_core;
    import adl_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 80;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam int SAT_ITEMS = 60;

    typedef struct {
        logic        kind;
        logic [14:0] audio;
        logic        last;
        logic [11:0] peak;
        logic [23:0] msq;
    } result_t;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  idx;
        logic        op;
        logic [11:0] val;
        bit          typed;
        logic [11:0] peak;
        logic [23:0] msq;
    } row_t;

    logic clk, rst_n;
    logic in_valid, in_stall, opcode;
    logic [11:0] sample_value;
    logic out_valid, out_stall, kind, frame_last;
    logic signed [14:0] audio_value;
    logic [11:0] peak_level;
    logic [23:0] mean_square;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    audio_decimator_with_loudness_core u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .sample_value(sample_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .audio_value(audio_value), .frame_last(frame_last),
        .peak_level(peak_level), .mean_square(mean_square),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // model state
    logic signed [15:0] delay_line [3][TAPS];
    int unsigned  wr_ptr [3];
    logic [2:0]   phase;
    int unsigned  frame_pos;
    logic [11:0]  peak_hold;
    logic [40:0]  sq_sum;
    logic [15:0]  sq_count;
    logic         m_capture;
    logic [7:0]   m_rate;
    logic         m_wide;

    result_t pending_results[$];
    int      errors;
    longint  cycles;
    bit      typed_cur;
    logic [11:0] typed_peak;
    logic [23:0] typed_msq;
    bit      no_gaps, quiet_out;
    int      stall_left;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    function automatic logic signed [15:0] fir_out(input int s);
        longint acc;
        int unsigned idx;
        logic signed [15:0] c [16];
        c = '{-16'sd86, 16'sd91, 16'sd422, -16'sd91, -16'sd1747, -16'sd934, 16'sd5604,
              16'sd13125, 16'sd13125, 16'sd5604, -16'sd934, -16'sd1747, -16'sd91,
              16'sd422, 16'sd91, -16'sd86};
        acc = 0;
        idx = wr_ptr[s];
        for (int i = 0; i < TAPS; i++) begin
            idx = (idx == 0) ? TAPS - 1 : idx - 1;
            acc += longint'(c[i]) * longint'(delay_line[s][idx]);
        end
        return 16'(acc >>> 15);
    endfunction

    function automatic void shift_in(input int s, input logic signed [15:0] v);
        delay_line[s][wr_ptr[s]] = v;
        wr_ptr[s] = (wr_ptr[s] + 1) % TAPS;
    endfunction

    function automatic void emit_audio(input logic signed [15:0] v, ref bit got,
                                       ref result_t r);
        int unsigned flen;
        logic signed [15:0] w;
        if (!m_capture)
            return;
        flen = m_wide ? FRAME_WIDE : FRAME_NARROW;
        w = m_wide ? v : (v >>> 4);
        r.kind = KIND_AUDIO;
        r.audio = w[14:0];
        r.peak = '0;
        r.msq = '0;
        if (frame_pos + 1 >= flen) begin
            r.last = 1'b1;
            frame_pos = 0;
        end
        else begin
            r.last = 1'b0;
            frame_pos++;
        end
        got = 1;
    endfunction

    function automatic void predict_item(input logic op, input logic [11:0] s);
        result_t r;
        bit got;
        logic signed [15:0] f;
        got = 0;
        r = '{default: '0};
        if (op == OP_READ) begin
            r.kind = KIND_REPORT;
            r.peak = peak_hold;
            r.msq = (sq_count != 0) ? 24'(sq_sum / sq_count) : '0;
            if (typed_cur) begin
                r.peak = typed_peak;
                r.msq = typed_msq;
            end
            peak_hold = '0;
            sq_sum = '0;
            sq_count = '0;
            pending_results.push_back(r);
            return;
        end
        if (s > peak_hold)
            peak_hold = s;
        if (sq_count != 16'hFFFF) begin
            sq_sum += 41'(s) * 41'(s);
            sq_count++;
        end
        phase = phase + 3'd1;
        if (m_rate == RATE_FULL)
            emit_audio(16'(s), got, r);
        shift_in(0, 16'(s));
        if (phase[0] == 1'b0) begin
            f = fir_out(0);
            shift_in(1, f);
            if (m_rate == RATE_HALF)
                emit_audio(f, got, r);
            if (phase[1:0] == 2'b00) begin
                f = fir_out(1);
                shift_in(2, f);
                if (m_rate == RATE_QUARTER)
                    emit_audio(f, got, r);
                if (phase == 3'd0) begin
                    f = fir_out(2);
                    if (m_rate == RATE_EIGHTH)
                        emit_audio(f, got, r);
                end
            end
        end
        if (got)
            pending_results.push_back(r);
    endfunction

    // prediction on input transfers, checking on output transfers
    always @(posedge clk) begin
        result_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** audio_decimator_with_loudness_core: FAILED **");
            $finish;
        end
        else if (rst_n) begin
            if (in_valid && !in_stall)
                predict_item(opcode, sample_value);
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end
                else begin
                    e = pending_results.pop_front();
                    if (kind !== e.kind) report_mismatch("kind", kind, e.kind);
                    if (audio_value !== e.audio)
                        report_mismatch("audio_value", audio_value, $signed(e.audio));
                    if (frame_last !== e.last) report_mismatch("frame_last", frame_last, e.last);
                    if (peak_level !== e.peak) report_mismatch("peak_level", peak_level, e.peak);
                    if (mean_square !== e.msq)
                        report_mismatch("mean_square", mean_square, e.msq);
                end
            end
        end
    end

    // receiver stalls: bursts of varied length, with quiet stretches
    always @(posedge clk) begin
        if (quiet_out) begin
            out_stall <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                      : $urandom_range(0, 3);
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    task automatic wait_idle();
        while (pending_results.size() != 0 || in_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CAPTURE: m_capture = data[0];
            REG_RATE:    m_rate = data;
            REG_WIDE:    m_wide = data[0];
            default: ;
        endcase
    endtask

    task automatic send_item(input logic op, input logic [11:0] s, input bit typed,
                             input logic [11:0] pk, input logic [23:0] ms);
        int gap;
        gap = 0;
        if (!no_gaps) begin
            case ($urandom_range(0, 9))
                0, 1, 2:    gap = $urandom_range(1, 3);
                3:          gap = $urandom_range(10, 60);
                default:    gap = 0;
            endcase
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        sample_value <= s;
        typed_cur = typed;
        typed_peak = pk;
        typed_msq = ms;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random(input int count, input int read_pct);
        logic [11:0] s;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 19))
                0:       s = 12'd0;
                1:       s = 12'hFFF;
                2:       s = 12'(1 << $urandom_range(0, 11));
                default: s = 12'($urandom);
            endcase
            if ($urandom_range(0, 99) < read_pct)
                send_item(OP_READ, 12'($urandom), 0, '0, '0);
            else
                send_item(OP_SAMPLE, s, 0, '0, '0);
        end
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    row_t directed[$];

    initial begin
        logic [7:0] rates [8];
        errors = 0;
        cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_SAMPLE;
        sample_value = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_CAPTURE;
        cfg_data = '0;
        no_gaps = 0;
        quiet_out = 0;
        stall_left = 0;
        typed_cur = 0;
        for (int s = 0; s < 3; s++) begin
            wr_ptr[s] = 0;
            for (int i = 0; i < TAPS; i++)
                delay_line[s][i] = '0;
        end
        phase = '0;
        frame_pos = 0;
        peak_hold = '0;
        sq_sum = '0;
        sq_count = '0;
        m_capture = 1'b0;
        m_rate = RATE_HALF;
        m_wide = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // read with zero count, then extremes with capture still off
        directed = '{
            '{0, REG_CAPTURE, OP_READ, 12'd0, 1, 12'd0, 24'd0},
            '{0, REG_CAPTURE, OP_SAMPLE, 12'hFFF, 0, 12'd0, 24'd0},
            '{0, REG_CAPTURE, OP_SAMPLE, 12'd0, 0, 12'd0, 24'd0},
            '{0, REG_CAPTURE, OP_READ, 12'd0, 1, 12'hFFF, 24'd8384512},
            '{1, REG_UNUSED, OP_SAMPLE, 12'hFF, 0, 12'd0, 24'd0},
            '{1, REG_CAPTURE, OP_SAMPLE, 12'hFF, 0, 12'd0, 24'd0},
            '{1, REG_RATE, OP_SAMPLE, 12'(RATE_FULL), 0, 12'd0, 24'd0},
            '{0, REG_CAPTURE, OP_SAMPLE, 12'hFFF, 0, 12'd0, 24'd0},
            '{0, REG_CAPTURE, OP_SAMPLE, 12'd0, 0, 12'd0, 24'd0},
            '{0, REG_CAPTURE, OP_SAMPLE, 12'd2048, 0, 12'd0, 24'd0},
            '{0, REG_CAPTURE, OP_SAMPLE, 12'd1, 0, 12'd0, 24'd0},
            '{1, REG_WIDE, OP_SAMPLE, 12'hFE, 0, 12'd0, 24'd0},
            '{0, REG_CAPTURE, OP_SAMPLE, 12'hFFF, 0, 12'd0, 24'd0},
            '{0, REG_CAPTURE, OP_SAMPLE, 12'd15, 0, 12'd0, 24'd0},
            '{1, REG_RATE, OP_SAMPLE, 12'(RATE_HALF), 0, 12'd0, 24'd0},
            '{0, REG_CAPTURE, OP_SAMPLE, 12'hFFF, 0, 12'd0, 24'd0},
            '{0, REG_CAPTURE, OP_SAMPLE, 12'd0, 0, 12'd0, 24'd0},
            '{0, REG_CAPTURE, OP_READ, 12'hFFF, 0, 12'd0, 24'd0}
        };
        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                write_reg(directed[i].idx, directed[i].val[7:0]);
            end
            else begin
                send_item(directed[i].op, directed[i].val, directed[i].typed,
                          directed[i].peak, directed[i].msq);
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end

        // random phases across all rates, both widths, unknown rates and capture off;
        // settings change mid-frame so shorter frames close early
        rates = '{RATE_FULL, RATE_HALF, RATE_QUARTER, RATE_EIGHTH,
                  RATE_FULL, 8'd0, 8'd255, RATE_EIGHTH};
        for (int p = 0; p < 12; p++) begin
            write_reg(REG_RATE, (p < 8) ? rates[p] : 8'(1 << $urandom_range(0, 3)));
            write_reg(REG_WIDE, 8'($urandom) ^ 8'(p & 1));
            write_reg(REG_CAPTURE, (p == 9) ? 8'd0 : 8'hFF);
            quiet_out = (p % 4 == 3);
            send_random(140, 4);
        end

        // back-to-back run with capture off, bracketed by reads
        write_reg(REG_CAPTURE, 8'd0);
        send_item(OP_READ, 12'd0, 0, '0, '0);
        no_gaps = 1;
        quiet_out = 1;
        send_random(SAT_ITEMS, 0);
        no_gaps = 0;
        quiet_out = 0;
        send_item(OP_READ, 12'd0, 0, '0, '0);
        in_valid <= 1'b0;
        @(posedge clk);
        write_reg(REG_CAPTURE, 8'd1);
        send_random(60, 5);

        wait_idle();
        if (errors == 0)
            $display("** audio_decimator_with_loudness_core: PASSED **");
        else
            $display("** audio_decimator_with_loudness_core: FAILED **");
        $finish;
    end

endmodule
